[rtl/mwpo_pkg.sv]
// Shared types and constants for the multi-waveform phase oscillator.
package mwpo_pkg;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave;

    localparam int FREQ_BITS    = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int SAMPLE_BITS  = 16;
    localparam int Q_DEPTH      = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FREQ = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAVE = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [FREQ_BITS-1:0] freq;
        t_wave                wave;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/mwpo_in_if.sv]
// Input tick channel: valid, ready and the restart flag.
interface mwpo_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

[rtl/mwpo_out_if.sv]
// Output sample channel: valid, ready and the signed sample value.
interface mwpo_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

[rtl/mwpo_queue.sv]
// Short phase queue between the accumulator front end and the waveform back end.
module mwpo_queue #(
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    input  logic [WIDTH-1:0]   i_push_data,
    input  logic               i_pop_ready,
    output logic               o_pop_valid,
    output logic [WIDTH-1:0]   o_pop_data,
    output mwpo_pkg::t_q_status o_status
);
    import mwpo_pkg::*;

    localparam int PTR_BITS = $clog2(Q_DEPTH);

    logic [WIDTH-1:0]    r_mem [Q_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS:0]   r_count;
    logic [PTR_BITS:0]   n_count;
    logic                w_push;
    logic                w_pop;

    assign o_status.full  = (r_count == (PTR_BITS + 1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push_valid && !o_status.full;
    assign w_pop  = i_pop_ready && !o_status.empty;
    assign o_pop_valid = !o_status.empty;
    assign o_pop_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[rtl/mwpo_front.sv]
// Front end: accepts ticks and advances the phase accumulator.
module mwpo_front #(
    parameter int PHASE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mwpo_in_if.sink               i_in,
    input  mwpo_pkg::t_cfg        i_cfg,
    input  mwpo_pkg::t_q_status   i_q_status,
    output logic                  o_push_valid,
    output logic [PHASE_BITS-1:0] o_push_phase
);
    import mwpo_pkg::*;

    localparam int SUM_BITS = (PHASE_BITS > FREQ_BITS) ? PHASE_BITS : FREQ_BITS;

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] w_base;
    logic [SUM_BITS-1:0]   w_sum;
    logic                  w_accept;

    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;

    // A restart clears the phase before the step of the same tick.
    assign w_base  = i_in.restart ? '0 : r_phase;
    assign w_sum   = SUM_BITS'(w_base) + SUM_BITS'(i_cfg.freq);
    assign n_phase = w_sum[PHASE_BITS-1:0];

    assign o_push_valid = w_accept;
    assign o_push_phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

[rtl/mwpo_back.sv]
// Back end: turns a phase into a sample of the selected waveform and holds it for output.
module mwpo_back #(
    parameter int PHASE_BITS         = 32,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mwpo_pkg::t_cfg        i_cfg,
    input  logic                  i_pop_valid,
    input  logic [PHASE_BITS-1:0] i_pop_phase,
    output logic                  o_pop_ready,
    mwpo_out_if.source            o_out
);
    import mwpo_pkg::*;

    // The table index is the quadrant offset scaled by the table depth.
    localparam int IDX_BITS  = $clog2(SINE_TABLE_ENTRIES);
    localparam int ADDR_BITS = IDX_BITS + 1;
    localparam int REST_BITS = PHASE_BITS - 2;
    localparam int PROD_BITS = REST_BITS + IDX_BITS;

    logic [14:0]                   w_sine [SINE_TABLE_ENTRIES+1];
    logic [1:0]                    w_quad;
    logic [PROD_BITS-1:0]          w_scaled;
    logic [IDX_BITS-1:0]           w_idx;
    logic [ADDR_BITS-1:0]          w_addr;
    logic [14:0]                   w_mag;
    logic signed [SAMPLE_BITS-1:0] w_sine_val;
    logic [15:0]                   w_top;
    logic signed [SAMPLE_BITS-1:0] w_saw;
    logic signed [16:0]            w_saw_ext;
    logic signed [16:0]            w_abs;
    logic signed [17:0]            w_tri_wide;
    logic signed [SAMPLE_BITS-1:0] w_tri;
    logic signed [SAMPLE_BITS-1:0] w_square;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic                          w_advance;
    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Quarter-wave table: Q30 Taylor sine through x^11, scaled to Q1.15 and clamped.
    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_sine
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = Q30_ONE - ((X2 * Q30_ONE) >> 30) / 64'd110;
        localparam logic [63:0] T2 = Q30_ONE - ((X2 * T1) >> 30) / 64'd72;
        localparam logic [63:0] T3 = Q30_ONE - ((X2 * T2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = Q30_ONE - ((X2 * T3) >> 30) / 64'd20;
        localparam logic [63:0] T5 = Q30_ONE - ((X2 * T4) >> 30) / 64'd6;
        localparam logic [63:0] V0 = (X * T5) >> 30;
        localparam logic [63:0] V1 = (V0 * 64'd32767 + (64'd1 << 29)) >> 30;
        localparam logic [63:0] V  = (V1 > 64'd32767) ? 64'd32767 : V1;
        assign w_sine[k] = V[14:0];
    end

    assign w_quad   = i_pop_phase[PHASE_BITS-1 -: 2];
    assign w_scaled = PROD_BITS'(i_pop_phase[REST_BITS-1:0])
                      * PROD_BITS'(SINE_TABLE_ENTRIES);
    assign w_idx    = w_scaled[PROD_BITS-1 -: IDX_BITS];
    assign w_addr = w_quad[0] ? ADDR_BITS'(SINE_TABLE_ENTRIES) - {1'b0, w_idx}
                              : {1'b0, w_idx};
    assign w_mag      = w_sine[w_addr];
    assign w_sine_val = w_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    assign w_top      = i_pop_phase[PHASE_BITS-1 -: 16];
    assign w_saw      = $signed({~w_top[15], w_top[14:0]});
    assign w_saw_ext  = 17'(w_saw);
    assign w_abs      = w_saw_ext[16] ? -w_saw_ext : w_saw_ext;
    assign w_tri_wide = {w_abs, 1'b0} - 18'sd32768;
    assign w_tri      = (w_tri_wide > 18'sd32767) ? SAMPLE_MAX : w_tri_wide[15:0];

    assign w_square = (i_pop_phase[PHASE_BITS-1] && |i_pop_phase[PHASE_BITS-2:0])
                      ? SAMPLE_MAX : SAMPLE_MIN;

    always_comb begin
        unique case (i_cfg.wave)
            WAVE_SINE:   w_sample = w_sine_val;
            WAVE_SAW:    w_sample = w_saw;
            WAVE_TRI:    w_sample = w_tri;
            WAVE_SQUARE: w_sample = w_square;
        endcase
    end

    assign w_advance   = !r_valid || o_out.ready;
    assign o_pop_ready = w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_pop_valid) begin
            r_sample <= w_sample;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.sample_value = r_sample;

endmodule

[rtl/multi_waveform_phase_oscillator.sv]
// Top level of the multi-waveform phase oscillator: configuration registers and assembly.
// The phase is queued at the input transfer edge; the back end registers the sample when it
// pops that phase, which an output stall or an older queued phase can delay.
// Throughput: one transfer per cycle on each side unless stalled; the phase is a single register.
// A two-entry queue and the output register let input and output stall independently.
// Reset clears the phase, the frequency word, the waveform select, the queue and the output valid.
module multi_waveform_phase_oscillator #(
    parameter int PHASE_BITS         = 32,
    parameter int SINE_TABLE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mwpo_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mwpo_pkg::FREQ_BITS-1:0]      i_cfg_data,
    mwpo_in_if.sink                             i_in,
    mwpo_out_if.source                          o_out
);
    import mwpo_pkg::*;

    t_cfg                  r_cfg;
    t_q_status             w_q_status;
    logic                  w_push_valid;
    logic [PHASE_BITS-1:0] w_push_phase;
    logic                  w_pop_valid;
    logic                  w_pop_ready;
    logic [PHASE_BITS-1:0] w_pop_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.freq <= '0;
            r_cfg.wave <= WAVE_SINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FREQ: r_cfg.freq <= i_cfg_data;
                REG_WAVE: r_cfg.wave <= t_wave'(i_cfg_data[1:0]);
            endcase
        end
    end

    mwpo_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (r_cfg),
        .i_q_status   (w_q_status),
        .o_push_valid (w_push_valid),
        .o_push_phase (w_push_phase)
    );

    mwpo_queue #(
        .WIDTH (PHASE_BITS)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_data  (w_push_phase),
        .i_pop_ready  (w_pop_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_data   (w_pop_phase),
        .o_status     (w_q_status)
    );

    mwpo_back #(
        .PHASE_BITS         (PHASE_BITS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_valid (w_pop_valid),
        .i_pop_phase (w_pop_phase),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push_valid)
        else $error("phase pushed into a full queue");

    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.restart) |-> (w_push_phase == PHASE_BITS'(r_cfg.freq)))
        else $error("restart tick did not start from zero phase");

    a_square_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_cfg.wave == WAVE_SQUARE)
            |-> (o_out.sample_value == SAMPLE_MAX || o_out.sample_value == SAMPLE_MIN))
        else $error("square output not at a rail");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_cfg.wave == WAVE_SINE) |-> (o_out.sample_value != SAMPLE_MIN))
        else $error("sine output reached negative full scale");

endmodule
